// ----- src/cspl_pkg.sv -----
package cspl_pkg;

  localparam int CoordW    = 32;
  localparam int FracBits  = 16;
  localparam int MaxPoints = 64;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CountW    = IdxW + 1;
  localparam int TW        = FracBits + 1;
  localparam int TenW      = 16;
  localparam int TenFrac   = 14;
  localparam int DiffW     = CoordW + 1;
  localparam int ScaleW    = TenW + 1;
  localparam int TanW      = CoordW + 3;
  localparam int BasisW    = FracBits + 4;
  localparam int ProdW     = TanW + BasisW;
  localparam int AccW      = ProdW + 2;

  typedef enum logic [2:0] {
    FUNC_APPEND     = 3'd0,
    FUNC_UPDATE     = 3'd1,
    FUNC_CLEAR      = 3'd2,
    FUNC_EVAL_SEG   = 3'd3,
    FUNC_EVAL_T     = 3'd4,
    FUNC_READ_POINT = 3'd5,
    FUNC_READ_TAN   = 3'd6,
    FUNC_COUNT      = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DECIDE,
    ST_MUL,
    ST_ACC
  } state_e;

  typedef struct packed {
    logic [2:0]               func;
    logic [IdxW-1:0]          index;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] pz;
    logic [TW-1:0]            t_pos;
  } cmd_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic [CountW-1:0]        point_count;
    status_e                  status;
  } res_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  typedef struct packed {
    logic [IdxW-1:0] a;
    logic [IdxW-1:0] b;
  } idx_pair_t;

  function automatic logic signed [CoordW-1:0] coord(input point_t p, input logic [1:0] k);
    logic signed [CoordW-1:0] r;
    case (k)
      2'd0:    r = p.x;
      2'd1:    r = p.y;
      default: r = p.z;
    endcase
    return r;
  endfunction

  // Neighbor pair for a Catmull-Rom tangent at point i of n.
  function automatic idx_pair_t tan_idx(input logic [CountW-1:0] i, input logic [CountW-1:0] n,
                                        input logic closed);
    logic [CountW-1:0] ii;
    logic [CountW-1:0] a;
    logic [CountW-1:0] b;
    idx_pair_t         r;
    ii = (i == n - CountW'(1) && closed) ? '0 : i;
    if (ii == '0) begin
      a = CountW'(1);
      b = closed ? n - CountW'(2) : '0;
    end else if (ii == n - CountW'(1)) begin
      a = ii;
      b = ii - CountW'(1);
    end else begin
      a = ii + CountW'(1);
      b = ii - CountW'(1);
    end
    r.a = a[IdxW-1:0];
    r.b = b[IdxW-1:0];
    return r;
  endfunction

  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'({1'b0, {(CoordW-1){1'b1}}});
    lo = -hi - AccW'(1);
    if (v > hi) return {1'b0, {(CoordW-1){1'b1}}};
    if (v < lo) return {1'b1, {(CoordW-1){1'b0}}};
    return v[CoordW-1:0];
  endfunction

endpackage

// ----- src/cardinal_spline_point_store_unit.sv -----
// Cardinal spline point store. Holds up to 64 control points (x, y, z in signed
// Q16.16) in a single-port-write, registered-read memory and evaluates the
// Catmull-Rom / cardinal Hermite curve through them on demand. An item is taken
// when start is high and busy is low; its one result appears on res_o for a
// single cycle with res_valid_o high and cannot be held off by the receiver.
// Append, update, clear, count and every error report answer in the cycle after
// the accept, and busy stays low. Read point, and curve evaluations that land
// on a control point (t of zero or one, or the last point as segment start),
// run eight memory reads through the one read port (closed-curve check pair,
// segment ends, two tangent neighbor pairs) and a decision state. A tangent read
// adds 5 and a full curve evaluation 20 multiply/accumulate steps, each a
// multiply state then an accumulate state, through one shared 35x20 multiplier.
// The tension register may only be written while busy is low and no result is
// pending.
module cardinal_spline_point_store_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  cspl_pkg::cmd_t       cmd_i,
  input  logic                 tension_we_i,
  input  logic [15:0]          tension_i,
  output logic                 res_valid_o,
  output cspl_pkg::res_t       res_o
);

  localparam int IdxW   = cspl_pkg::IdxW;
  localparam int CountW = cspl_pkg::CountW;
  localparam int TW     = cspl_pkg::TW;
  localparam int FB     = cspl_pkg::FracBits;
  localparam int TanW   = cspl_pkg::TanW;
  localparam int BasisW = cspl_pkg::BasisW;
  localparam int ProdW  = cspl_pkg::ProdW;
  localparam int AccW   = cspl_pkg::AccW;
  localparam int DiffW  = cspl_pkg::DiffW;
  localparam int ScaleW = cspl_pkg::ScaleW;
  localparam int SegW   = TW + CountW;
  localparam logic [4:0] LastStep = 5'd19;
  localparam logic [4:0] TanLast  = 5'd4;

  // control point memory, registered read
  cspl_pkg::point_t mem [cspl_pkg::MaxPoints];
  cspl_pkg::point_t rdata_q;
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  cspl_pkg::point_t mem_wdata;
  logic [IdxW-1:0]  rd_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[rd_addr];
  end

  cspl_pkg::state_e state_q, state_d;
  logic [3:0]                  cnt_q;
  logic [4:0]                  step_q;
  cspl_pkg::func_e             func_q;
  logic [IdxW-1:0]             seg_q;
  logic [TW-1:0]               tl_q;
  logic [CountW-1:0]           count_q;
  logic signed [15:0]          tension_q;
  cspl_pkg::point_t            pts_q [8];
  logic [FB-1:0]               t2_q, t3_q;
  logic signed [TanW-1:0]      m1_q [3];
  logic signed [TanW-1:0]      m2_q [3];
  logic signed [ProdW-1:0]     prod_q;
  logic signed [AccW-1:0]      acc_q;
  cspl_pkg::res_t              res_q;
  logic                        res_valid_q;
  logic                        res_valid_d;

  cspl_pkg::func_e             cmd_func;
  cspl_pkg::res_t              res_acc;
  logic [TW-1:0]               t_clamp;
  logic [SegW-1:0]             s_glob;
  logic                        accept;
  logic                        closed;
  logic [CountW-1:0]           seg_ext;
  cspl_pkg::idx_pair_t         tan1, tan2;
  logic signed [BasisW-1:0]    h00, h01, h10, h11, hsel;
  logic signed [ScaleW-1:0]    scale;
  logic signed [TanW-1:0]      mul_a;
  logic signed [BasisW-1:0]    mul_b;
  logic [4:0]                  sidx;
  logic [1:0]                  kk;
  logic [1:0]                  tk;
  logic signed [DiffW-1:0]     dsel;
  logic signed [TanW-1:0]      tan_res;
  logic signed [AccW-1:0]      acc_sum;
  logic signed [cspl_pkg::CoordW-1:0] acc_out;

  assign accept   = start && !busy;
  assign busy     = (state_q != cspl_pkg::ST_IDLE);
  assign cmd_func = cspl_pkg::func_e'(cmd_i.func);
  // t above one is taken as one
  assign t_clamp  = (cmd_i.t_pos > TW'(1 << FB)) ? TW'(1 << FB) : cmd_i.t_pos;
  // global t: segment in the integer part, local t in the fraction
  assign s_glob   = SegW'(t_clamp) * SegW'(count_q - CountW'(1));
  assign closed   = (pts_q[0] == pts_q[1]);
  assign seg_ext  = CountW'(seg_q);
  assign tan1     = cspl_pkg::tan_idx(seg_ext, count_q, closed);
  assign tan2     = cspl_pkg::tan_idx(seg_ext + CountW'(1), count_q, closed);
  assign scale    = ScaleW'(1 << cspl_pkg::TenFrac) - ScaleW'(tension_q);

  // result fields known at accept time: count after the item and its status
  always_comb begin
    res_acc = '{out_x: '0, out_y: '0, out_z: '0,
                point_count: count_q, status: cspl_pkg::STATUS_OK};
    case (cmd_func)
      cspl_pkg::FUNC_APPEND: begin
        if (count_q[IdxW]) res_acc.status = cspl_pkg::STATUS_FULL;
        else res_acc.point_count = count_q + CountW'(1);
      end
      cspl_pkg::FUNC_CLEAR: res_acc.point_count = '0;
      cspl_pkg::FUNC_UPDATE, cspl_pkg::FUNC_EVAL_SEG, cspl_pkg::FUNC_READ_POINT: begin
        if (!(CountW'(cmd_i.index) < count_q)) res_acc.status = cspl_pkg::STATUS_RANGE;
      end
      cspl_pkg::FUNC_EVAL_T: begin
        if (count_q == '0) res_acc.status = cspl_pkg::STATUS_RANGE;
      end
      cspl_pkg::FUNC_READ_TAN: begin
        if (!(count_q >= CountW'(2) && CountW'(cmd_i.index) < count_q)) begin
          res_acc.status = cspl_pkg::STATUS_RANGE;
        end
      end
      default: ;
    endcase
  end

  // Hermite basis in Q16 from the registered powers of t
  always_comb begin
    logic signed [BasisW-1:0] t1, t2, t3;
    t1  = BasisW'(tl_q);
    t2  = BasisW'(t2_q);
    t3  = BasisW'(t3_q);
    h00 = (t3 <<< 1) - (t2 + (t2 <<< 1)) + BasisW'(1 << FB);
    h01 = (t2 + (t2 <<< 1)) - (t3 <<< 1);
    h10 = t3 - (t2 <<< 1) + t1;
    h11 = t3 - t2;
  end

  // multiplier operand select: step 0 t*t, step 1 t2*t, steps 2..7 tangents,
  // steps 8..19 four basis terms for each coordinate
  always_comb begin
    sidx = step_q - 5'd8;
    kk   = sidx[3:2];
    tk   = (step_q >= 5'd5) ? 2'(step_q - 5'd5) : 2'(step_q - 5'd2);
    if (step_q >= 5'd5) begin
      dsel = DiffW'(cspl_pkg::coord(pts_q[6], tk)) - DiffW'(cspl_pkg::coord(pts_q[7], tk));
    end else begin
      dsel = DiffW'(cspl_pkg::coord(pts_q[4], tk)) - DiffW'(cspl_pkg::coord(pts_q[5], tk));
    end
    case (sidx[1:0])
      2'd0:    hsel = h00;
      2'd1:    hsel = h01;
      2'd2:    hsel = h10;
      default: hsel = h11;
    endcase
    if (step_q == 5'd0) begin
      mul_a = TanW'(tl_q);
      mul_b = BasisW'(tl_q);
    end else if (step_q == 5'd1) begin
      mul_a = TanW'(t2_q);
      mul_b = BasisW'(tl_q);
    end else if (step_q < 5'd8) begin
      mul_a = TanW'(dsel);
      mul_b = BasisW'(scale);
    end else begin
      case (sidx[1:0])
        2'd0:    mul_a = TanW'(cspl_pkg::coord(pts_q[2], kk));
        2'd1:    mul_a = TanW'(cspl_pkg::coord(pts_q[3], kk));
        2'd2:    mul_a = m1_q[kk];
        default: mul_a = m2_q[kk];
      endcase
      mul_b = hsel;
    end
  end

  // half and Q1.14 tension scale folded into one floor shift
  assign tan_res = TanW'(prod_q >>> (cspl_pkg::TenFrac + 1));
  assign acc_sum = acc_q + AccW'(prod_q);
  assign acc_out = cspl_pkg::sat_coord(acc_sum >>> FB);

  // next state, result strobe, memory control
  always_comb begin
    state_d     = state_q;
    res_valid_d = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = cmd_i.index;
    mem_wdata   = '{x: cmd_i.px, y: cmd_i.py, z: cmd_i.pz};
    case (cnt_q)
      4'd0:    rd_addr = '0;
      4'd1:    rd_addr = IdxW'(count_q - CountW'(1));
      4'd2:    rd_addr = seg_q;
      4'd3:    rd_addr = seg_q + IdxW'(1);
      4'd4:    rd_addr = tan1.a;
      4'd5:    rd_addr = tan1.b;
      4'd6:    rd_addr = tan2.a;
      default: rd_addr = tan2.b;
    endcase
    case (state_q)
      cspl_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd_func)
            cspl_pkg::FUNC_APPEND: begin
              res_valid_d = 1'b1;
              if (!count_q[IdxW]) begin
                mem_we    = 1'b1;
                mem_waddr = count_q[IdxW-1:0];
              end
            end
            cspl_pkg::FUNC_UPDATE: begin
              res_valid_d = 1'b1;
              mem_we      = (CountW'(cmd_i.index) < count_q);
            end
            cspl_pkg::FUNC_EVAL_SEG, cspl_pkg::FUNC_READ_POINT: begin
              if (CountW'(cmd_i.index) < count_q) state_d = cspl_pkg::ST_READ;
              else res_valid_d = 1'b1;
            end
            cspl_pkg::FUNC_EVAL_T: begin
              if (count_q != '0) state_d = cspl_pkg::ST_READ;
              else res_valid_d = 1'b1;
            end
            cspl_pkg::FUNC_READ_TAN: begin
              if (count_q >= CountW'(2) && CountW'(cmd_i.index) < count_q) begin
                state_d = cspl_pkg::ST_READ;
              end else begin
                res_valid_d = 1'b1;
              end
            end
            default: res_valid_d = 1'b1;
          endcase
        end
      end
      cspl_pkg::ST_READ: begin
        if (cnt_q == 4'd8) state_d = cspl_pkg::ST_DECIDE;
      end
      cspl_pkg::ST_DECIDE: begin
        if (func_q == cspl_pkg::FUNC_READ_TAN) begin
          state_d = cspl_pkg::ST_MUL;
        end else if (func_q == cspl_pkg::FUNC_READ_POINT ||
                     seg_ext + CountW'(1) == count_q || tl_q == '0 || tl_q[FB]) begin
          state_d = cspl_pkg::ST_IDLE;
        end else begin
          state_d = cspl_pkg::ST_MUL;
        end
        res_valid_d = (state_d == cspl_pkg::ST_IDLE);
      end
      cspl_pkg::ST_MUL: state_d = cspl_pkg::ST_ACC;
      cspl_pkg::ST_ACC: begin
        if (step_q == LastStep ||
            (func_q == cspl_pkg::FUNC_READ_TAN && step_q == TanLast)) begin
          state_d = cspl_pkg::ST_IDLE;
        end else begin
          state_d = cspl_pkg::ST_MUL;
        end
        res_valid_d = (state_d == cspl_pkg::ST_IDLE);
      end
      default: state_d = cspl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cspl_pkg::ST_IDLE;
      count_q     <= '0;
      tension_q   <= '0;
      res_valid_q <= 1'b0;
      cnt_q       <= '0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (tension_we_i) tension_q <= tension_i;
      case (state_q)
        cspl_pkg::ST_IDLE: begin
          cnt_q  <= '0;
          step_q <= '0;
          if (accept) begin
            case (cmd_func)
              cspl_pkg::FUNC_APPEND: begin
                if (!count_q[IdxW]) count_q <= count_q + CountW'(1);
              end
              cspl_pkg::FUNC_CLEAR: count_q <= '0;
              default: ;
            endcase
          end
        end
        cspl_pkg::ST_READ: begin
          cnt_q <= cnt_q + 4'd1;
        end
        cspl_pkg::ST_ACC: begin
          step_q <= step_q + 5'd1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      cspl_pkg::ST_IDLE: begin
        if (accept) begin
          func_q <= cmd_func;
          res_q  <= res_acc;
          if (cmd_func == cspl_pkg::FUNC_EVAL_T) begin
            seg_q <= s_glob[FB +: IdxW];
            tl_q  <= TW'(s_glob[FB-1:0]);
          end else begin
            seg_q <= cmd_i.index;
            tl_q  <= t_clamp;
          end
        end
      end
      cspl_pkg::ST_READ: begin
        if (cnt_q != 4'd0) pts_q[3'(cnt_q - 4'd1)] <= rdata_q;
      end
      cspl_pkg::ST_DECIDE: begin
        // landing on a control point needs no arithmetic; a tangent read
        // starts from zero and fills in one coordinate per step
        if (func_q == cspl_pkg::FUNC_READ_TAN) begin
          res_q.out_x <= '0;
          res_q.out_y <= '0;
          res_q.out_z <= '0;
        end else if (func_q == cspl_pkg::FUNC_READ_POINT ||
                     seg_ext + CountW'(1) == count_q || tl_q == '0) begin
          res_q.out_x <= pts_q[2].x;
          res_q.out_y <= pts_q[2].y;
          res_q.out_z <= pts_q[2].z;
        end else begin
          res_q.out_x <= pts_q[3].x;
          res_q.out_y <= pts_q[3].y;
          res_q.out_z <= pts_q[3].z;
        end
      end
      cspl_pkg::ST_MUL: begin
        prod_q <= mul_a * mul_b;
      end
      cspl_pkg::ST_ACC: begin
        if (step_q == 5'd0) begin
          t2_q <= prod_q[FB +: FB];
        end else if (step_q == 5'd1) begin
          t3_q <= prod_q[FB +: FB];
        end else if (step_q < 5'd5) begin
          m1_q[tk] <= tan_res;
          if (func_q == cspl_pkg::FUNC_READ_TAN) begin
            case (tk)
              2'd0:    res_q.out_x <= cspl_pkg::sat_coord(AccW'(tan_res));
              2'd1:    res_q.out_y <= cspl_pkg::sat_coord(AccW'(tan_res));
              default: res_q.out_z <= cspl_pkg::sat_coord(AccW'(tan_res));
            endcase
          end
        end else if (step_q < 5'd8) begin
          m2_q[tk] <= tan_res;
        end else begin
          if (sidx[1:0] == 2'd0) acc_q <= AccW'(prod_q);
          else acc_q <= acc_sum;
          if (sidx[1:0] == 2'd3) begin
            case (kk)
              2'd0:    res_q.out_x <= acc_out;
              2'd1:    res_q.out_y <= acc_out;
              default: res_q.out_z <= acc_out;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTH
  a_accept_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || res_valid_o))
    else $error("accepted item neither busy nor answered");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(cspl_pkg::MaxPoints))
    else $error("point count beyond capacity");
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != cspl_pkg::STATUS_OK) |->
      (res_o.out_x == '0 && res_o.out_y == '0 && res_o.out_z == '0))
    else $error("error result carries coordinates");
  a_no_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && busy) |-> $past(state_q) != cspl_pkg::ST_IDLE)
    else $error("result while a new item runs");
`endif

endmodule
